[sv/sfr_pkg.sv]
// Shared constants, types and control bundles for the stream find/replace core.
package sfr_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int OUT_DEPTH       = 8;
	localparam int LEN_W           = 4;
	localparam int REG_W           = 64;
	localparam int IDX_W           = 2;

	typedef logic [7:0]       byte_t;
	typedef logic [LEN_W-1:0] len_t;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// Window cell control: capture the incoming byte, or take the neighbor's byte
	typedef struct packed {
		logic ins;
		logic shift;
	} win_ctl_t;

	// Output cell control: load a new burst, or advance toward the head
	typedef struct packed {
		logic load;
		logic shift;
	} out_ctl_t;

endpackage

[sv/stream_find_replace_core.sv]
// Top level of the streaming find and replace core: window cells, burst cells, control.
//
//  channel  | signals                                 | payload
//  ---------+-----------------------------------------+-----------------------------------
//  s        | s_tvalid s_tready s_tdata s_tlast       | tdata[7:0] data_byte; tlast stream_last
//  m        | m_tvalid m_tready m_tdata m_tlast m_tuser| tdata[7:0] out_byte; tlast run_last;
//           |                                         | tuser[0] byte_valid, tuser[1] stream_end
//  cfg      | cfg_wr_en cfg_index cfg_wdata           | write-only register port
//
// An input request's window update and match compare happen in the accepting cycle, and
// its 0..8 results are loaded into the output cell row. Results leave one per cycle
// while m_tready is high, the output cell row draining one byte per pop.
// s_tready stays high while the last result of the previous burst is being taken.
// Reset clears the configuration, the window count and the output count.
module stream_find_replace_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] data_byte
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // [7:0] out_byte
	output logic                         m_tlast,
	output logic [1:0]                   m_tuser,   // [0] byte_valid, [1] stream_end
	input  logic                         cfg_wr_en,
	input  logic [sfr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::REG_W-1:0]    cfg_wdata
);

	// Configuration registers
	logic [sfr_pkg::REG_W-1:0] pattern_q;
	logic [sfr_pkg::REG_W-1:0] repl_q;
	sfr_pkg::len_t             plen_cfg_q;
	sfr_pkg::len_t             rlen_cfg_q;

	// Control state
	sfr_pkg::len_t win_cnt_q;
	sfr_pkg::len_t out_cnt_q;
	logic          bvalid_q;
	logic          send_q;

	sfr_pkg::len_t plen, rlen, cnt_eff, cnt_new, cnt_next, n_res;
	logic          in_acc, pop, full, all_hit, match, bare;

	sfr_pkg::win_ctl_t win_ctl [sfr_pkg::MAX_PATTERN];
	sfr_pkg::byte_t    win_cur [sfr_pkg::MAX_PATTERN];
	logic [sfr_pkg::MAX_PATTERN-1:0] win_hit;

	sfr_pkg::out_ctl_t out_ctl;
	sfr_pkg::byte_t    out_load [sfr_pkg::OUT_DEPTH];
	sfr_pkg::byte_t    out_cur  [sfr_pkg::OUT_DEPTH];

	// Handshakes
	assign in_acc   = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (out_cnt_q == '0) || ((out_cnt_q == sfr_pkg::LEN_W'(1)) && m_tready);

	// Lengths clamped to the supported maxima
	always_comb begin
		plen = (plen_cfg_q > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN)) ?
			sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN) : plen_cfg_q;
		rlen = (rlen_cfg_q > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT)) ?
			sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT) : rlen_cfg_q;
	end

	// Window fill level and match detection
	always_comb begin
		cnt_eff = (win_cnt_q >= plen) ? '0 : win_cnt_q;
		cnt_new = cnt_eff + sfr_pkg::LEN_W'(1);
		full    = (plen != '0) && (cnt_new == plen);
		all_hit = 1'b1;
		for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
			if ((sfr_pkg::LEN_W'(i) < plen) && !win_hit[i]) begin
				all_hit = 1'b0;
			end
		end
		match = full && all_hit;
	end

	// Result count for this request and the next window level
	always_comb begin
		if (plen == '0) begin
			n_res    = sfr_pkg::LEN_W'(1);
			cnt_next = '0;
		end else if (match) begin
			n_res    = rlen;
			cnt_next = '0;
		end else if (full) begin
			n_res    = s_tlast ? plen : sfr_pkg::LEN_W'(1);
			cnt_next = s_tlast ? '0 : plen - sfr_pkg::LEN_W'(1);
		end else begin
			n_res    = s_tlast ? cnt_new : '0;
			cnt_next = s_tlast ? '0 : cnt_new;
		end
		bare = s_tlast && (n_res == '0);
	end

	// Window cell row
	for (genvar i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin : g_win
		sfr_pkg::byte_t nbr;
		if (i == sfr_pkg::MAX_PATTERN - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = win_cur[i+1];
		end
		assign win_ctl[i].ins   = in_acc && (cnt_eff == sfr_pkg::LEN_W'(i));
		assign win_ctl[i].shift = in_acc && full && !match && !s_tlast;
		sfr_win_cell u_cell (
			.clk      (clk),
			.ctl      (win_ctl[i]),
			.in_byte  (s_tdata),
			.nbr_byte (nbr),
			.pat_byte (pattern_q[8*i +: 8]),
			.cur_byte (win_cur[i]),
			.hit      (win_hit[i])
		);
	end

	// Burst contents: replacement text or the window, zero for a bare end marker
	always_comb begin
		for (int j = 0; j < sfr_pkg::OUT_DEPTH; j++) begin
			if (bare) begin
				out_load[j] = '0;
			end else if (match) begin
				out_load[j] = repl_q[8*j +: 8];
			end else begin
				out_load[j] = win_cur[j];
			end
		end
	end

	assign out_ctl.load  = in_acc && ((n_res != '0) || bare);
	assign out_ctl.shift = pop;

	// Output cell row, head at index 0
	for (genvar j = 0; j < sfr_pkg::OUT_DEPTH; j++) begin : g_out
		sfr_pkg::byte_t nbr;
		if (j == sfr_pkg::OUT_DEPTH - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = out_cur[j+1];
		end
		sfr_out_cell u_cell (
			.clk       (clk),
			.ctl       (out_ctl),
			.load_byte (out_load[j]),
			.nbr_byte  (nbr),
			.cur_byte  (out_cur[j])
		);
	end

	// Output port
	assign m_tvalid   = (out_cnt_q != '0);
	assign m_tdata    = out_cur[0];
	assign m_tlast    = (out_cnt_q == sfr_pkg::LEN_W'(1));
	assign m_tuser[0] = bvalid_q;
	assign m_tuser[1] = send_q && m_tlast;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			repl_q     <= '0;
			plen_cfg_q <= '0;
			rlen_cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (sfr_pkg::cfg_reg_t'(cfg_index))
				sfr_pkg::REG_PATTERN_BYTES:      pattern_q  <= cfg_wdata;
				sfr_pkg::REG_PATTERN_LENGTH:     plen_cfg_q <= cfg_wdata[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES:  repl_q     <= cfg_wdata;
				sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_cfg_q <= cfg_wdata[sfr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Window level and burst bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
			out_cnt_q <= '0;
			bvalid_q  <= 1'b0;
			send_q    <= 1'b0;
		end else begin
			if (cfg_wr_en && (cfg_index == sfr_pkg::REG_PATTERN_LENGTH)) begin
				win_cnt_q <= '0;
			end else if (in_acc) begin
				win_cnt_q <= cnt_next;
			end
			if (out_ctl.load) begin
				out_cnt_q <= bare ? sfr_pkg::LEN_W'(1) : n_res;
				bvalid_q  <= !bare;
				send_q    <= s_tlast;
			end else if (pop) begin
				out_cnt_q <= out_cnt_q - sfr_pkg::LEN_W'(1);
			end
		end
	end

endmodule

[sv/sfr_win_cell.sv]
// One window cell: holds one pending byte and compares it against its pattern byte.
module sfr_win_cell (
	input  logic              clk,
	input  sfr_pkg::win_ctl_t ctl,
	input  sfr_pkg::byte_t    in_byte,
	input  sfr_pkg::byte_t    nbr_byte,
	input  sfr_pkg::byte_t    pat_byte,
	output sfr_pkg::byte_t    cur_byte,
	output logic              hit
);

	sfr_pkg::byte_t byte_q;

	// View of the cell including a byte being inserted this cycle
	always_comb begin
		cur_byte = ctl.ins ? in_byte : byte_q;
		hit      = (cur_byte == pat_byte);
	end

	// Shift from the younger neighbor on release, else capture the new byte
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= nbr_byte;
		end else if (ctl.ins) begin
			byte_q <= in_byte;
		end
	end

endmodule

[sv/sfr_out_cell.sv]
// One output cell: holds one byte of a result burst and hands it toward the head.
module sfr_out_cell (
	input  logic              clk,
	input  sfr_pkg::out_ctl_t ctl,
	input  sfr_pkg::byte_t    load_byte,
	input  sfr_pkg::byte_t    nbr_byte,
	output sfr_pkg::byte_t    cur_byte
);

	sfr_pkg::byte_t byte_q;

	assign cur_byte = byte_q;

	// New burst wins over draining
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= load_byte;
		end else if (ctl.shift) begin
			byte_q <= nbr_byte;
		end
	end

endmodule
